// ----- src/swf_trw_pkg.sv -----
// ----------------------------------------------------------------------------
// swf_trw_pkg
// shared types and constants for the swf tag record walker
// ----------------------------------------------------------------------------
package swf_trw_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
    localparam logic [9:0]  WATCH_TAG_RESET     = 10'd21;

    localparam logic [7:0]  RECT_NBITS_MASK     = 8'hF8;
    localparam logic [15:0] HDR_TYPE_MASK       = 16'hFFC0;
    localparam logic [15:0] HDR_LEN_MASK        = 16'h003F;
    localparam logic [5:0]  LEN_LONG_FORM       = 6'h3F;

    typedef enum logic [1:0] {
        EV_HEADER = 2'd0,
        EV_END    = 2'd1,
        EV_TRUNC  = 2'd2
    } trw_event_t;

    typedef enum logic [6:0] {
        PH_RECT0   = 7'b0000001,
        PH_SKIPHDR = 7'b0000010,
        PH_TAGLO   = 7'b0000100,
        PH_TAGHI   = 7'b0001000,
        PH_LONGLEN = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_DONE    = 7'b1000000
    } trw_phase_t;

    typedef struct packed {
        logic [1:0]  event_code;
        logic [9:0]  record_type;
        logic [31:0] record_length;
        logic [31:0] record_offset;
        logic        long_form;
        logic        type_match;
        logic        last_of_run;
    } trw_result_t;

    // up to two results come out of one body byte
    typedef struct packed {
        logic [1:0]  count;
        trw_result_t slot0;
        trw_result_t slot1;
    } trw_push_t;

endpackage

// ----- src/swf_trw_parser.sv -----
// ----------------------------------------------------------------------------
// swf_trw_parser
// byte-wide header/tag framer, one body byte per accepted transaction
// ----------------------------------------------------------------------------
module swf_trw_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             body_byte,
    input  logic                   final_byte,
    input  logic [9:0]             watch_tag_type,
    output swf_trw_pkg::trw_push_t push
);
    import swf_trw_pkg::*;

    trw_phase_t  phase_reg, phase_next;
    logic [31:0] skip_reg, skip_next;
    logic [7:0]  hdr_lo_reg, hdr_lo_next;
    logic [9:0]  ptype_reg, ptype_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  lcnt_reg, lcnt_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] start_reg, start_next;

    logic [31:0] skip_dec;
    logic [7:0]  rect_bytes;
    logic [15:0] hdr;
    logic [9:0]  hdr_type;
    logic [5:0]  hdr_len;
    logic [31:0] acc_merged;
    logic        ended;
    logic        rec_valid;
    trw_result_t rec;
    trw_result_t trunc;

    assign skip_dec   = skip_reg - 32'd1;
    assign rect_bytes = (8'd12 + ((body_byte & RECT_NBITS_MASK) >> 1)) >> 3;
    assign hdr        = {body_byte, hdr_lo_reg};
    assign hdr_type   = 10'((hdr & HDR_TYPE_MASK) >> 6);
    assign hdr_len    = 6'(hdr & HDR_LEN_MASK);

    always_comb
    begin
        acc_merged = acc_reg;
        case (lcnt_reg)
            2'd0:    acc_merged[7:0]   = acc_reg[7:0]   | body_byte;
            2'd1:    acc_merged[15:8]  = acc_reg[15:8]  | body_byte;
            2'd2:    acc_merged[23:16] = acc_reg[23:16] | body_byte;
            default: acc_merged[31:24] = acc_reg[31:24] | body_byte;
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        hdr_lo_next = hdr_lo_reg;
        ptype_next  = ptype_reg;
        acc_next    = acc_reg;
        lcnt_next   = lcnt_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        ended       = 1'b0;
        rec_valid   = 1'b0;
        rec         = '0;

        if (phase_reg == PH_TAGLO || phase_reg == PH_TAGHI ||
            phase_reg == PH_LONGLEN || phase_reg == PH_PAYLOAD)
        begin
            pos_next = pos_reg + 32'd1;
        end

        unique case (phase_reg)
            PH_RECT0:
            begin
                skip_next  = {24'd0, rect_bytes} + 32'd3;
                phase_next = PH_SKIPHDR;
            end
            PH_SKIPHDR, PH_PAYLOAD:
            begin
                skip_next = skip_dec;
                if (skip_dec == 32'd0)
                begin
                    phase_next = PH_TAGLO;
                end
            end
            PH_TAGLO:
            begin
                start_next  = pos_reg;
                hdr_lo_next = body_byte;
                phase_next  = PH_TAGHI;
            end
            PH_TAGHI:
            begin
                ptype_next = hdr_type;
                if (hdr_type == 10'd0)
                begin
                    rec_valid         = 1'b1;
                    rec.event_code    = EV_END;
                    rec.record_offset = start_reg;
                    phase_next        = PH_DONE;
                    ended             = 1'b1;
                end
                else if (hdr_len != LEN_LONG_FORM)
                begin
                    rec_valid         = 1'b1;
                    rec.event_code    = EV_HEADER;
                    rec.record_type   = hdr_type;
                    rec.record_length = {26'd0, hdr_len};
                    rec.record_offset = start_reg;
                    rec.type_match    = (hdr_type == watch_tag_type);
                    skip_next         = {26'd0, hdr_len};
                    phase_next        = (hdr_len == 6'd0) ? PH_TAGLO : PH_PAYLOAD;
                end
                else
                begin
                    acc_next   = '0;
                    lcnt_next  = 2'd0;
                    phase_next = PH_LONGLEN;
                end
            end
            PH_LONGLEN:
            begin
                acc_next = acc_merged;
                if (lcnt_reg == 2'd3)
                begin
                    lcnt_next         = 2'd0;
                    rec_valid         = 1'b1;
                    rec.event_code    = EV_HEADER;
                    rec.record_type   = ptype_reg;
                    rec.record_length = acc_merged;
                    rec.record_offset = start_reg;
                    rec.long_form     = 1'b1;
                    rec.type_match    = (ptype_reg == watch_tag_type);
                    skip_next         = acc_merged;
                    phase_next        = (acc_merged == 32'd0) ? PH_TAGLO : PH_PAYLOAD;
                end
                else
                begin
                    lcnt_next = lcnt_reg + 2'd1;
                end
            end
            default:
            begin
                // after the end tag: bytes are dropped until the final one
                ended = 1'b1;
            end
        endcase

        if (final_byte)
        begin
            phase_next  = PH_RECT0;
            skip_next   = '0;
            hdr_lo_next = '0;
            ptype_next  = '0;
            acc_next    = '0;
            lcnt_next   = '0;
            pos_next    = '0;
            start_next  = '0;
        end
    end

    always_comb
    begin
        trunc               = '0;
        trunc.event_code    = EV_TRUNC;
        trunc.record_offset = pos_reg + ((phase_reg == PH_TAGLO || phase_reg == PH_TAGHI ||
                              phase_reg == PH_LONGLEN || phase_reg == PH_PAYLOAD)
                              ? 32'd1 : 32'd0);
        trunc.last_of_run   = 1'b1;

        push = '0;
        if (accept)
        begin
            if (rec_valid && final_byte && !ended)
            begin
                push.count = 2'd2;
                push.slot0 = rec;
                push.slot1 = trunc;
            end
            else if (rec_valid)
            begin
                push.count             = 2'd1;
                push.slot0             = rec;
                push.slot0.last_of_run = 1'b1;
            end
            else if (final_byte && !ended)
            begin
                push.count = 2'd1;
                push.slot0 = trunc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RECT0;
            skip_reg   <= '0;
            hdr_lo_reg <= '0;
            ptype_reg  <= '0;
            acc_reg    <= '0;
            lcnt_reg   <= '0;
            pos_reg    <= '0;
            start_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            skip_reg   <= skip_next;
            hdr_lo_reg <= hdr_lo_next;
            ptype_reg  <= ptype_next;
            acc_reg    <= acc_next;
            lcnt_reg   <= lcnt_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
        end
    end

    a_two_is_header_then_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.slot0.event_code == EV_HEADER &&
                               push.slot1.event_code == EV_TRUNC)
        else $error("two results must be a header followed by truncation");

    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && final_byte |=> phase_reg == PH_RECT0 && pos_reg == 32'd0)
        else $error("parser did not return to start after the final byte");

    a_no_push_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> push.count == 2'd0)
        else $error("results produced without an accepted byte");

endmodule

// ----- src/swf_trw_queue.sv -----
// ----------------------------------------------------------------------------
// swf_trw_queue
// result queue taking up to two results a cycle and giving one a cycle unless out_stall is high
// ----------------------------------------------------------------------------
module swf_trw_queue #(
    parameter int unsigned DEPTH = swf_trw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  swf_trw_pkg::trw_push_t   push,
    output logic                     full,
    output logic                     out_valid,
    input  logic                     out_stall,
    output swf_trw_pkg::trw_result_t head
);
    import swf_trw_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    trw_result_t     mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic [AW-1:0]   wr_ptr_inc;
    logic [AW-1:0]   wr_ptr_inc2;
    logic [AW-1:0]   rd_ptr_inc;
    logic            pop;

    assign out_valid  = (count_reg != '0);
    assign pop        = out_valid && !out_stall;
    assign head       = mem_reg[rd_ptr_reg];
    // room must exist for the worst case of two results from one byte
    assign full       = (count_reg > (AW+1)'(DEPTH - 2));

    // pointers wrap at the queue depth
    assign wr_ptr_inc  = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
    assign wr_ptr_inc2 = (wr_ptr_inc == AW'(DEPTH - 1)) ? '0 : wr_ptr_inc + AW'(1);
    assign rd_ptr_inc  = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);

    always_comb
    begin
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = wr_ptr_inc2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
    end

    assign rd_ptr_next = pop ? rd_ptr_inc : rd_ptr_reg;
    assign count_next  = count_reg + (AW+1)'(push.count) - (AW+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.slot0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.slot1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH))
        else $error("result queue overflow");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> !full)
        else $error("push into a full result queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers and count disagree");

endmodule

// ----- src/swf_tag_record_walker_core.sv -----
// ----------------------------------------------------------------------------
// swf_tag_record_walker_core
// walks the tag records of an uncompressed swf body, while in_stall is low one byte per cycle
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   body_byte, final_byte
//  out      source     out_valid / out_stall event_code .. last_of_run
//  cfg      sink       cfg_write             cfg_data (watch tag type)
//
//  one body byte is taken every cycle while in_stall is low; its results land
//  in the queue at the same edge and leave one per cycle from the queue head
//  while out_stall is low; a byte that completes a header and is also the
//  final byte gives two results and so holds the output side for both
//  in_stall rises when the queue holds more than QUEUE_DEPTH-2 results
//  reset clears the parser and queue at once and sets the watch type to 21
// ----------------------------------------------------------------------------
module swf_tag_record_walker_core #(
    parameter int unsigned QUEUE_DEPTH = swf_trw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  body_byte,
    input  logic        final_byte,

    input  logic        cfg_write,
    input  logic [9:0]  cfg_data,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_code,
    output logic [9:0]  record_type,
    output logic [31:0] record_length,
    output logic [31:0] record_offset,
    output logic        long_form,
    output logic        type_match,
    output logic        last_of_run
);
    import swf_trw_pkg::*;

    logic        watch_hit;
    logic [9:0]  watch_type_reg;
    logic        accept;
    logic        full;
    trw_push_t   push;
    trw_result_t head;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watch_type_reg <= WATCH_TAG_RESET;
        end
        else if (cfg_write)
        begin
            watch_type_reg <= cfg_data;
        end
    end

    swf_trw_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .body_byte      (body_byte),
        .final_byte     (final_byte),
        .watch_tag_type (watch_type_reg),
        .push           (push)
    );

    swf_trw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign event_code    = head.event_code;
    assign record_type   = head.record_type;
    assign record_length = head.record_length;
    assign record_offset = head.record_offset;
    assign long_form     = head.long_form;
    assign type_match    = head.type_match;
    assign last_of_run   = head.last_of_run;

    // transaction-level check: a short header result's match flag follows its type
    assign watch_hit = (head.record_type == watch_type_reg);

    a_match_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && head.event_code != EV_HEADER |-> !head.type_match && !head.long_form)
        else $error("match or long form flag on a non-header result");

    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && head.event_code == EV_TRUNC |-> head.last_of_run)
        else $error("truncation result not marked last of run");

    a_short_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && head.event_code == EV_HEADER && !head.long_form &&
        $stable(watch_type_reg) |-> head.type_match == watch_hit || !$past(rst_n))
        else $error("short header match flag disagrees with watch type");

endmodule
